// File: rtl/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression package
// Item types, round constants and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned MsgWords = 16;
	localparam int unsigned Rounds = 64;
	localparam int unsigned ChainWords = 8;
	localparam int unsigned QueueDepthDef = 4;

	localparam logic MODE_CHAIN = 1'b0;
	localparam logic MODE_MSG = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] data_word;
		logic [2:0]  chain_index;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        last_word;
	} out_item_t;

	// Queue entry between front and back: a chaining load, or a full block
	// start (the 16th message word, flagged).
	typedef struct packed {
		logic        is_block;
		logic [31:0] data_word;
		logic [2:0]  chain_index;
	} cmd_t;

	typedef logic [31:0] word_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t round_const(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		round_const = k;
	endfunction

endpackage

// File: rtl/sha256_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts items, counts message words and forwards chaining loads and block
// starts to the command queue. Message words go straight to the back's window.
// ----------------------------------------------------------------------------
module sha256_front import sha256_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t in_item,
	input  logic     push,
	output logic     full,
	// window write port toward the back end
	output logic       win_we,
	output logic [3:0] win_addr,
	output word_t      win_data,
	// command queue write side
	output logic       cmd_push,
	output cmd_t       cmd,
	input  logic       cmd_full,
	// back is busy with the window (from block start until the results are taken)
	input  logic       win_busy
);

	logic [3:0] word_count_q;
	logic       acc;

	// A message word may only land when the window is free; block start also
	// needs queue room, so hold all items while either is blocked.
	assign full = cmd_full | win_busy;
	assign acc = push & ~full;

	assign win_we = acc & (in_item.mode == MODE_MSG);
	assign win_addr = word_count_q;
	assign win_data = in_item.data_word;

	assign cmd_push = acc & ((in_item.mode == MODE_CHAIN) || (word_count_q == 4'd15));
	assign cmd.is_block = (in_item.mode == MODE_MSG);
	assign cmd.data_word = in_item.data_word;
	assign cmd.chain_index = in_item.chain_index;

	// message word counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
		end else if (win_we) begin
			word_count_q <= word_count_q + 4'd1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		win_we && cmd_push |-> word_count_q == 4'd15)
		else $error("block start off the 16th word");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		win_we |-> !win_busy)
		else $error("window written during rounds");

endmodule

// File: rtl/sha256_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 command queue
// Small register FIFO that decouples front and back.
// ----------------------------------------------------------------------------
module sha256_cmd_queue import sha256_pkg::*; #(
	parameter int unsigned Depth = QueueDepthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_data,
	output logic is_full,
	input  logic rd,
	output cmd_t rd_data,
	output logic is_empty
);

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	cmd_t            mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign is_full = (cnt_q == (AW+1)'(Depth));
	assign is_empty = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	// payload storage
	always_ff @(posedge clk) begin
		if (wr && !is_full) mem_q[wp_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !is_full) begin
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd && !is_empty) begin
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr && !is_full) - (AW+1)'(rd && !is_empty);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(Depth))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr && !is_full && !(rd && !is_empty) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count not incremented");
	assert property (@(posedge clk) disable iff (!arst_n)
		rd && !is_empty && !wr |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count not decremented");

endmodule

// File: rtl/sha256_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 back end
// Owns the chaining words, the 16-word schedule window and the round logic.
// Runs 64 rounds one per cycle, a feed-forward add, then streams 8 words.
// ----------------------------------------------------------------------------
module sha256_back import sha256_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       win_we,
	input  logic [3:0] win_addr,
	input  word_t      win_data,
	output logic       win_busy,
	input  cmd_t       cmd,
	input  logic       cmd_empty,
	output logic       cmd_pop,
	output out_item_t  out_item,
	output logic       empty,
	input  logic       pop
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_ADD   = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t     state_q;
	word_t      chain_q [ChainWords];
	word_t      win_q [MsgWords];
	word_t      v_q [ChainWords];
	logic [5:0] round_q;
	logic [2:0] emit_q;

	word_t      w_t, t1, t2;
	logic [3:0] slot;

	// window busy from block start until the add finishes
	assign win_busy = (state_q == ST_ROUND) || (state_q == ST_ADD) ||
		(state_q == ST_IDLE && !cmd_empty && cmd.is_block);
	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;

	// schedule word and round arithmetic
	always_comb begin
		slot = round_q[3:0];
		if (round_q >= 6'd16) begin
			w_t = small_sigma1(win_q[slot - 4'd2]) + win_q[slot - 4'd7]
				+ small_sigma0(win_q[slot - 4'd15]) + win_q[slot];
		end else begin
			w_t = win_q[slot];
		end
		t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_const(round_q) + w_t;
		t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
			^ (v_q[1] & v_q[2]));
	end

	assign empty = (state_q != ST_EMIT);
	assign out_item.digest_word = chain_q[emit_q];
	assign out_item.digest_index = emit_q;
	assign out_item.last_word = (emit_q == 3'd7);

	// schedule window: front writes while idle, rounds rewrite in place
	always_ff @(posedge clk) begin
		if (win_we) begin
			win_q[win_addr] <= win_data;
		end else if (state_q == ST_ROUND) begin
			win_q[slot] <= w_t;
		end
	end

	// sequencer, chaining words and working variables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			emit_q <= '0;
			for (int i = 0; i < ChainWords; i++) begin
				chain_q[i] <= '0;
				v_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						if (cmd.is_block) begin
							for (int i = 0; i < ChainWords; i++) v_q[i] <= chain_q[i];
							round_q <= '0;
							state_q <= ST_ROUND;
						end else begin
							chain_q[cmd.chain_index] <= cmd.data_word;
						end
					end
				end
				ST_ROUND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < ChainWords; i++) chain_q[i] <= chain_q[i] + v_q[i];
					emit_q <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (pop) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && round_q == 6'd63 |=> state_q == ST_ADD)
		else $error("round count did not end the block");
	assert property (@(posedge clk) disable iff (!arst_n)
		win_we |-> state_q == ST_IDLE || state_q == ST_EMIT)
		else $error("window write during rounds");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && pop && emit_q == 3'd7 |=> state_q == ST_IDLE)
		else $error("emit did not end after eight words");

endmodule

// File: rtl/sha256_block_compression.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 block compression
// Queue-style input and output around a one-round-per-cycle SHA-256 core.
// ----------------------------------------------------------------------------
// Input channel: push/full carrying in_item (mode, data_word, chain_index).
//   mode 0 loads chaining word chain_index; mode 1 stores the next message word.
// Output channel: empty/pop carrying out_item (digest_word, digest_index,
//   last_word); eight items per block, index 0 first, last_word on index 7.
// Items are taken one per cycle while full is low; chaining loads and block
// starts go into a short command queue, message words are written straight
// into the 16-word schedule window. The 16th message word starts the block:
// 64 rounds at one per cycle on the round unit, a feed-forward add, then the
// eight result words. full stays high while rounds run and while results
// wait, so input stalls when the receiver does not pop. Reset clears chaining
// words, counters and the queue; the schedule window is written before it is
// read.
// ----------------------------------------------------------------------------
module sha256_block_compression import sha256_pkg::*; #(
	parameter int unsigned QueueDepth = QueueDepthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  logic      push,
	output logic      full,
	output out_item_t out_item,
	output logic      empty,
	input  logic      pop
);

	logic       win_we, win_busy, front_full;
	logic [3:0] win_addr;
	word_t      win_data;
	logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_t       cmd_in, cmd_out;

	// hold input while the results of a block are being emitted
	logic blk_pend;
	assign blk_pend = !empty;

	sha256_front u_front (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .push(push), .full(front_full),
		.win_we(win_we), .win_addr(win_addr), .win_data(win_data),
		.cmd_push(cmd_push), .cmd(cmd_in), .cmd_full(cmd_full),
		.win_busy(win_busy | blk_pend)
	);

	assign full = front_full;

	sha256_cmd_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr(cmd_push), .wr_data(cmd_in),
		.is_full(cmd_full), .rd(cmd_pop), .rd_data(cmd_out), .is_empty(cmd_empty)
	);

	sha256_back u_back (
		.clk(clk), .arst_n(arst_n), .win_we(win_we), .win_addr(win_addr),
		.win_data(win_data), .win_busy(win_busy), .cmd(cmd_out), .cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop), .out_item(out_item), .empty(empty), .pop(pop)
	);

endmodule
